/* hdl/btc_pkg.sv */
`default_nettype none
package btc_pkg;

    // Register indexes on the configuration channel
    typedef enum logic [2:0] {
        REG_OFFSET   = 3'd0,
        REG_TEMP     = 3'd1,
        REG_PRESS_LO = 3'd2,
        REG_PRESS_HI = 3'd3
    } t_reg_idx;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Divide-by-32767 pipeline: one magnitude stage, four digit folds, one fix-up
    localparam int DIV_STAGES = 6;
    localparam int DIV_FOLDS = DIV_STAGES - 2;
    localparam int DIV_SHIFT = 15;
    localparam logic [63:0] DIV_K = 64'd32767;

    // Coefficient scaling k * c + d
    typedef struct packed {
        logic signed [20:0] k;
        logic signed [31:0] d;
    } t_scale;

    localparam t_scale SC_A1  = '{k: 21'sd3608,   d: -32'sd1731677965};
    localparam t_scale SC_A2  = '{k: 21'sd16889,  d: -32'sd87619360};
    localparam t_scale SC_BT1 = '{k: 21'sd2982,   d: 32'sd107370906};
    localparam t_scale SC_BT2 = '{k: 21'sd329854, d: 32'sd108083093};
    localparam t_scale SC_BP1 = '{k: 21'sd19923,  d: 32'sd1133836764};
    localparam t_scale SC_B11 = '{k: 21'sd2406,   d: 32'sd118215883};
    localparam t_scale SC_BP2 = '{k: 21'sd3079,   d: -32'sd181579595};
    localparam t_scale SC_B12 = '{k: 21'sd6846,   d: 32'sd85590281};
    localparam t_scale SC_B21 = '{k: 21'sd13836,  d: 32'sd79333336};
    localparam t_scale SC_BP3 = '{k: 21'sd2915,   d: 32'sd157155561};

    localparam logic signed [63:0] P_MAX = 64'sd4194303;
    localparam logic signed [63:0] P_MIN = -64'sd4194304;

    // Scale one signed 16-bit coefficient; the result fits in 36 bits
    function automatic logic signed [35:0] scale_coef(input logic signed [15:0] c,
                                                      input t_scale s);
        logic signed [35:0] prod;
        prod = 36'(c * s.k);
        return prod + 36'(s.d);
    endfunction

endpackage
`default_nettype wire

/* hdl/btc_div32767.sv */
`default_nettype none
module btc_div32767 (
    input  wire logic                              i_clk,
    input  wire logic [btc_pkg::DIV_STAGES-1:0]    i_en,
    input  wire logic signed [63:0]                i_dividend,
    output logic signed [63:0]                     o_quotient
);
    import btc_pkg::*;

    logic              r_neg [0:DIV_FOLDS];
    logic [63:0]       r_m   [0:DIV_FOLDS];
    logic [63:0]       r_q   [1:DIV_FOLDS];
    logic signed [63:0] r_out;
    logic [63:0]       c_hi  [1:DIV_FOLDS];
    logic [63:0]       c_lo  [1:DIV_FOLDS];
    logic [63:0]       c_qf;

    // Split each residue into a high part and a 15-bit digit; 2^15 = 32767 + 1
    always_comb begin
        for (int k = 1; k <= DIV_FOLDS; k++) begin
            c_hi[k] = r_m[k-1] >> DIV_SHIFT;
            c_lo[k] = r_m[k-1] & ((64'd1 << DIV_SHIFT) - 64'd1);
        end
        c_qf = r_q[DIV_FOLDS] + ((r_m[DIV_FOLDS] >= DIV_K) ? 64'd1 : 64'd0);
    end

    always_ff @(posedge i_clk) begin
        // Take magnitude so the quotient truncates toward zero
        if (i_en[0]) begin
            r_neg[0] <= i_dividend[63];
            r_m[0]   <= i_dividend[63] ? 64'(-i_dividend) : 64'(i_dividend);
        end
        // Fold: q += hi, m = hi + lo
        if (i_en[1]) begin
            r_neg[1] <= r_neg[0];
            r_m[1]   <= c_hi[1] + c_lo[1];
            r_q[1]   <= c_hi[1];
        end
        for (int k = 2; k <= DIV_FOLDS; k++) begin
            if (i_en[k]) begin
                r_neg[k] <= r_neg[k-1];
                r_m[k]   <= c_hi[k] + c_lo[k];
                r_q[k]   <= r_q[k-1] + c_hi[k];
            end
        end
        // Final correction and sign
        if (i_en[DIV_STAGES-1]) begin
            r_out <= r_neg[DIV_FOLDS] ? $signed(-c_qf) : $signed(c_qf);
        end
    end

    assign o_quotient = r_out;

endmodule
`default_nettype wire

/* hdl/baro_temp_compensation.sv */
`default_nettype none
// Polynomial compensation for a 24-bit barometric sensor. Each input transaction carries a
// raw pressure and a raw temperature word; each output transaction carries temperature in
// 1/256 degC (wrapped to 16 bits) and pressure in 1/16 Pa (saturated to 23 bits). The block
// takes one transaction per cycle until an output stall backs up to the input; its depth is set
// by the multiplier stages and the two six-stage divide-by-32767 pipelines. Stalls on the output
// only back up as far as the pipeline is full. The user must write calibration registers over
// the cfg channel only while the block is idle; the block itself does not enforce this.
module baro_temp_compensation (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [47:0]                     i_s_axis_tdata,  // [23:0] raw_pressure, [47:24] raw_temperature
    // master stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [39:0]                          o_m_axis_tdata,  // [15:0] temperature_q8, [38:16] pressure_q4, [39] zero
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [btc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [btc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import btc_pkg::*;

    localparam int N       = 23;
    localparam int ST_DIV1 = 5;
    localparam int ST_TX   = ST_DIV1 + DIV_STAGES;
    localparam int ST_DIV2 = 17;
    localparam int ST_OUT  = ST_DIV2 + DIV_STAGES;

    // configuration registers
    logic [39:0] r_offset;
    logic [31:0] r_temp;
    logic [63:0] r_plo;
    logic [63:0] r_phi;

    // scaled coefficients
    logic signed [19:0] r_a0, r_b00;
    logic signed [31:0] r_a1, r_a2, r_bt1, r_bp1, r_b11, r_bp2, r_b12, r_b21, r_bp3;
    logic signed [35:0] r_bt2;

    // pipeline control
    logic [N:1]   r_valid;
    logic [N+1:1] c_en;

    // carried operands
    logic signed [23:0] r_dt [1:2];
    logic signed [23:0] r_dp [1:13];
    logic signed [15:0] r_tx [ST_TX:N];

    // temperature path
    logic signed [55:0] r2_a1dt;
    logic signed [54:0] r2_a2dt;
    logic signed [55:0] r3_w1;
    logic signed [54:0] r3_t2;
    logic signed [63:0] r4_sum;
    logic signed [63:0] c_q1;
    logic signed [40:0] c3_t;
    logic signed [64:0] c3_prod;
    logic signed [63:0] c11_sum;

    // pressure path
    logic signed [47:0] r12_bt1tx, r12_b11tx, r12_b12tx, r12_b21tx;
    logic signed [51:0] r12_bt2tx;
    logic signed [55:0] r12_bp1dp, r12_bp2dp, r12_bp3dp;
    logic signed [63:0] r13_w1, r13_w3, r13_x, r13_y, r13_z, r13_u, r13_v;
    logic signed [63:0] r14_w1, r14_w3, r14_zq, r14_uq, r14_vq;
    logic signed [63:0] r15_w1, r15_w3, r16_w1;
    logic signed [63:0] c_q2, c23_p;
    logic signed [50:0] c13_bt2h;
    logic signed [43:0] c13_b11h, c13_bp3h;
    logic signed [42:0] c13_bp2h;
    logic signed [41:0] c13_b21h, c14_zh;
    logic signed [40:0] c14_uh, c14_vh;
    logic signed [63:0] c13_w3p;
    logic signed [22:0] r23_p;

    // Configuration writes; out-of-range indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_temp   <= '0;
            r_plo    <= '0;
            r_phi    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_OFFSET:   r_offset <= i_cfg_data[39:0];
                REG_TEMP:     r_temp   <= i_cfg_data[31:0];
                REG_PRESS_LO: r_plo    <= i_cfg_data;
                REG_PRESS_HI: r_phi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Scale coefficients once per cycle from the register values
    always_ff @(posedge i_clk) begin
        r_a0  <= r_offset[39:20];
        r_b00 <= r_offset[19:0];
        r_a1  <= 32'(scale_coef(r_temp[31:16], SC_A1));
        r_a2  <= 32'(scale_coef(r_temp[15:0],  SC_A2));
        r_bt1 <= 32'(scale_coef(r_plo[63:48], SC_BT1));
        r_bt2 <= scale_coef(r_plo[47:32], SC_BT2);
        r_bp1 <= 32'(scale_coef(r_plo[31:16], SC_BP1));
        r_b11 <= 32'(scale_coef(r_plo[15:0],  SC_B11));
        r_bp2 <= 32'(scale_coef(r_phi[63:48], SC_BP2));
        r_b12 <= 32'(scale_coef(r_phi[47:32], SC_B12));
        r_b21 <= 32'(scale_coef(r_phi[31:16], SC_B21));
        r_bp3 <= 32'(scale_coef(r_phi[15:0],  SC_BP3));
    end

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        c_en[N+1] = i_m_axis_tready;
        for (int k = N; k >= 1; k--) begin
            c_en[k] = !r_valid[k] || c_en[k+1];
        end
    end

    assign o_s_axis_tready = c_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (c_en[1]) r_valid[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= N; k++) begin
                if (c_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Carry dt, dp and tx along the pipeline
    always_ff @(posedge i_clk) begin
        if (c_en[1]) begin
            r_dp[1] <= {~i_s_axis_tdata[23], i_s_axis_tdata[22:0]};
            r_dt[1] <= {~i_s_axis_tdata[47], i_s_axis_tdata[46:24]};
        end
        if (c_en[2]) r_dt[2] <= r_dt[1];
        for (int k = 2; k <= 13; k++) begin
            if (c_en[k]) r_dp[k] <= r_dp[k-1];
        end
        if (c_en[ST_TX]) r_tx[ST_TX] <= c11_sum[19:4];
        for (int k = ST_TX + 1; k <= N; k++) begin
            if (c_en[k]) r_tx[k] <= r_tx[k-1];
        end
    end

    // Temperature polynomial
    always_comb begin
        c3_t    = r2_a2dt[54:14];
        c3_prod = 65'(c3_t * r_dt[2]);
        c11_sum = 64'(r_a0) + (c_q1 >>> 19);
    end

    always_ff @(posedge i_clk) begin
        if (c_en[2]) begin
            r2_a1dt <= 56'(r_a1 * r_dt[1]);
            r2_a2dt <= 55'(r_a2 * r_dt[1]);
        end
        if (c_en[3]) begin
            r3_w1 <= r2_a1dt;
            r3_t2 <= c3_prod[64:10];
        end
        if (c_en[4]) r4_sum <= 64'(r3_w1) + 64'(r3_t2);
    end

    btc_div32767 u_div_temp (
        .i_clk      (i_clk),
        .i_en       (c_en[ST_DIV1 + DIV_STAGES - 1:ST_DIV1]),
        .i_dividend (r4_sum),
        .o_quotient (c_q1)
    );

    // Pressure polynomial
    always_comb begin
        c13_bt2h = r12_bt2tx[51:1];
        c13_w3p  = 64'(c13_bt2h * r_tx[12]);
        c13_b11h = r12_b11tx[47:4];
        c13_bp2h = r12_bp2dp[55:13];
        c13_b21h = r12_b21tx[47:6];
        c13_bp3h = r12_bp3dp[55:12];
        c14_zh   = r13_z[63:22];
        c14_uh   = r13_u[63:23];
        c14_vh   = r13_v[63:23];
        c23_p    = (c_q2 >>> 11) + 64'(r_b00);
    end

    always_ff @(posedge i_clk) begin
        if (c_en[12]) begin
            r12_bt1tx <= 48'(r_bt1 * r_tx[ST_TX]);
            r12_bt2tx <= 52'(r_bt2 * r_tx[ST_TX]);
            r12_b11tx <= 48'(r_b11 * r_tx[ST_TX]);
            r12_b12tx <= 48'(r_b12 * r_tx[ST_TX]);
            r12_b21tx <= 48'(r_b21 * r_tx[ST_TX]);
            r12_bp1dp <= 56'(r_bp1 * r_dp[11]);
            r12_bp2dp <= 56'(r_bp2 * r_dp[11]);
            r12_bp3dp <= 56'(r_bp3 * r_dp[11]);
        end
        if (c_en[13]) begin
            r13_w1 <= 64'(r12_bt1tx) + 64'(r12_bp1dp >>> 5);
            r13_w3 <= c13_w3p >>> 8;
            r13_x  <= 64'(c13_b11h * r_dp[12]);
            r13_y  <= 64'(c13_bp2h * r_dp[12]);
            r13_z  <= 64'(r12_b12tx * r_tx[12]);
            r13_u  <= 64'(c13_b21h * r_dp[12]);
            r13_v  <= 64'(c13_bp3h * r_dp[12]);
        end
        if (c_en[14]) begin
            r14_w1 <= r13_w1;
            r14_w3 <= r13_w3 + (r13_x >>> 1) + (r13_y >>> 1);
            r14_zq <= 64'(c14_zh * r_dp[13]);
            r14_uq <= 64'(c14_uh * r_dp[13]);
            r14_vq <= 64'(c14_vh * r_dp[13]);
        end
        if (c_en[15]) begin
            r15_w1 <= r14_w1 + (r14_w3 >>> 14);
            r15_w3 <= (r14_zq >>> 1) + (r14_uq >>> 1) + r14_vq;
        end
        if (c_en[16]) r16_w1 <= r15_w1 + (r15_w3 >>> 15);
        // Saturate into the output register
        if (c_en[ST_OUT]) begin
            priority if (c23_p > P_MAX) r23_p <= P_MAX[22:0];
            else if (c23_p < P_MIN)     r23_p <= P_MIN[22:0];
            else                        r23_p <= c23_p[22:0];
        end
    end

    btc_div32767 u_div_press (
        .i_clk      (i_clk),
        .i_en       (c_en[ST_DIV2 + DIV_STAGES - 1:ST_DIV2]),
        .i_dividend (r16_w1),
        .o_quotient (c_q2)
    );

    assign o_m_axis_tvalid = r_valid[N];
    assign o_m_axis_tdata  = {1'b0, r23_p, r_tx[N]};

`ifndef SYNTH
    // A full pipeline under output stall must refuse input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid) && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while pipeline full and stalled");

    // An item in the last compute stage reaches the output register next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[N-1] && !r_valid[N] |=> r_valid[N])
        else $error("item lost before output register");

    // A stalled result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[N] && !i_m_axis_tready |=> r_valid[N])
        else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

/* test/tb_baro_temp_compensation.sv */
`default_nettype none
module tb_baro_temp_compensation;
    import btc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] IDX_UNUSED = 3'd5;
    localparam longint DIVISOR = 64'sd32767;
    localparam int LATENCY_WAIT = 40;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [23:0] raw_p;
        logic [23:0] raw_t;
        int gap;
    } t_sample;

    typedef struct {
        logic [15:0] temp_q8;
        logic [22:0] press_q4;
    } t_reading;

    logic i_clk;
    logic i_rst_n;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    baro_temp_compensation i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Calibration shadow
    logic [63:0] cal_offset;
    logic [63:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;

    t_sample samples_pending[$];
    t_reading readings_due[$];
    int errors;
    int cycles;
    int tx_wait;
    int rx_wait;
    bit rx_fast;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint coef(input logic [63:0] reg_v, input int lsb,
                                    input longint k, input longint d);
        logic [15:0] c;
        c = reg_v[lsb +: 16];
        return longint'(signed'(c)) * k + d;
    endfunction

    // Temperature and pressure polynomials with 64-bit wrapping arithmetic
    function automatic t_reading compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
        logic [23:0] dp24, dt24;
        logic [19:0] a0_f, b00_f;
        longint dp, dt, a0, b00, a1, a2, bt1, bt2, bp1, b11, bp2, b12, b21, bp3;
        longint w1, w2, w3, tx, p;
        t_reading r;
        dp24 = raw_p - 24'h800000;
        dt24 = raw_t - 24'h800000;
        dp = longint'(signed'(dp24));
        dt = longint'(signed'(dt24));
        a0_f = cal_offset[39:20];
        b00_f = cal_offset[19:0];
        a0 = longint'(signed'(a0_f));
        b00 = longint'(signed'(b00_f));
        a1 = coef(cal_temp, 16, 3608, -1731677965);
        a2 = coef(cal_temp, 0, 16889, -87619360);
        bt1 = coef(cal_press_lo, 48, 2982, 107370906);
        bt2 = coef(cal_press_lo, 32, 329854, 108083093);
        bp1 = coef(cal_press_lo, 16, 19923, 1133836764);
        b11 = coef(cal_press_lo, 0, 2406, 118215883);
        bp2 = coef(cal_press_hi, 48, 3079, -181579595);
        b12 = coef(cal_press_hi, 32, 6846, 85590281);
        b21 = coef(cal_press_hi, 16, 13836, 79333336);
        bp3 = coef(cal_press_hi, 0, 2915, 157155561);

        w1 = a1 * dt;
        w2 = (a2 * dt) >>> 14;
        w2 = (w2 * dt) >>> 10;
        w2 = ((w1 + w2) / DIVISOR) >>> 19;
        tx = longint'(shortint'((a0 + w2) >>> 4));

        w1 = bt1 * tx;
        w1 += (bp1 * dp) >>> 5;
        w2 = (bt2 * tx) >>> 1;
        w3 = (w2 * tx) >>> 8;
        w2 = (b11 * tx) >>> 4;
        w3 += (w2 * dp) >>> 1;
        w2 = (bp2 * dp) >>> 13;
        w3 += (w2 * dp) >>> 1;
        w1 += w3 >>> 14;
        w2 = ((b12 * tx) * tx) >>> 22;
        w3 = (w2 * dp) >>> 1;
        w2 = (b21 * tx) >>> 6;
        w2 = (w2 * dp) >>> 23;
        w3 += (w2 * dp) >>> 1;
        w2 = (bp3 * dp) >>> 12;
        w2 = (w2 * dp) >>> 23;
        w3 += w2 * dp;
        w1 += w3 >>> 15;
        w1 = (w1 / DIVISOR) >>> 11;
        p = w1 + b00;
        if (p > 4194303) p = 4194303;
        if (p < -4194304) p = -4194304;

        r.temp_q8 = tx[15:0];
        r.press_q4 = p[22:0];
        return r;
    endfunction

    // Reset sequence
    initial begin
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("baro_temp_compensation verification failed");
            $finish;
        end
    end

    // Long receiver hold-off countdown
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Driver: offer queued samples, predict on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
            tx_wait = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                readings_due.push_back(compensate(samples_pending[0].raw_p,
                                                  samples_pending[0].raw_t));
                void'(samples_pending.pop_front());
                tx_wait = (samples_pending.size() > 0) ? samples_pending[0].gap : 0;
            end else if (!i_s_axis_tvalid && tx_wait > 0) begin
                tx_wait--;
            end
            if (tx_wait == 0 && samples_pending.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {samples_pending[0].raw_t, samples_pending[0].raw_p};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (readings_due.size() == 0) begin
                    report($sformatf("unexpected result %h", o_m_axis_tdata));
                end else begin
                    want = readings_due.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.temp_q8)
                        report($sformatf("temperature_q8 got %h want %h",
                                         o_m_axis_tdata[15:0], want.temp_q8));
                    if (o_m_axis_tdata[38:16] !== want.press_q4)
                        report($sformatf("pressure_q4 got %h want %h",
                                         o_m_axis_tdata[38:16], want.press_q4));
                end
                rx_wait = rx_fast ? 0 : $urandom_range(0, 19);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_OFFSET:   cal_offset = value & 64'hFF_FFFF_FFFF;
            REG_TEMP:     cal_temp = value & 64'hFFFF_FFFF;
            REG_PRESS_LO: cal_press_lo = value;
            REG_PRESS_HI: cal_press_hi = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] v0, input logic [63:0] v1,
                             input logic [63:0] v2, input logic [63:0] v3);
        cfg_write(REG_OFFSET, v0);
        cfg_write(REG_TEMP, v1);
        cfg_write(REG_PRESS_LO, v2);
        cfg_write(REG_PRESS_HI, v3);
    endtask

    task automatic push_sample(input logic [23:0] p, input logic [23:0] t, input int gap);
        t_sample s;
        s.raw_p = p;
        s.raw_t = t;
        s.gap = gap;
        @(negedge i_clk);
        samples_pending.push_back(s);
    endtask

    task automatic drain();
        while (samples_pending.size() > 0 || readings_due.size() > 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            4: return 24'h800000 + 24'($urandom_range(0, 4095)) - 24'd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [23:0] corners[5];
        logic [63:0] r0, r1, r2, r3;
        bit tx_fast;
        corners = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000, 24'hFFFFFF};
        errors = 0;
        cycles = 0;
        hold_left = 0;
        rx_fast = 0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        cal_offset = '0;
        cal_temp = '0;
        cal_press_lo = '0;
        cal_press_hi = '0;
        @(posedge i_rst_n);

        // Field corners with reset calibration
        foreach (corners[i])
            foreach (corners[j])
                push_sample(corners[i], corners[j], $urandom_range(0, 19));
        drain();

        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: write_all(64'h7FFFF_7FFFF, 64'h7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                             64'h7FFF_7FFF_7FFF_7FFF);
                1: write_all(64'h80000_80000, 64'h8000_8000, 64'h8000_8000_8000_8000,
                             64'h8000_8000_8000_8000);
                2: write_all('1, '1, '1, '1);
                3: write_all('0, '0, '0, '0);
                default: begin
                    r0 = {$urandom, $urandom};
                    r1 = {$urandom, $urandom};
                    r2 = {$urandom, $urandom};
                    r3 = {$urandom, $urandom};
                    write_all(r0, r1, r2, r3);
                end
            endcase
            if (ph == 6) cfg_write(IDX_UNUSED, {$urandom, $urandom});
            tx_fast = (ph % 3 == 1) || (ph == 5);
            rx_fast = (ph % 4 == 2);
            for (int n = 0; n < 150; n++) begin
                push_sample(pick_word(), pick_word(), tx_fast ? 0 : $urandom_range(0, 19));
                // Stall the output long enough to fill the pipeline
                if (ph == 5 && n == 10) hold_left = 400;
            end
            drain();
        end

        if (errors == 0) begin
            $display("baro_temp_compensation verification clean");
        end else begin
            $display("baro_temp_compensation verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hdl/btc_pkg.sv
hdl/btc_div32767.sv
hdl/baro_temp_compensation.sv
test/tb_baro_temp_compensation.sv
